/* rtl/core/rrtt_pkg.sv */
// shared types and constants for the region translation table
package rrtt_pkg;
  localparam int ENTRIES_DEF  = 16;
  localparam int REF_BITS_DEF = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGING    = 1'd1;

  typedef enum logic [1:0] {
    MODE_REG   = 2'd0,
    MODE_DEREG = 2'd1,
    MODE_RES   = 2'd2,
    MODE_REL   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_NEW      = 4'd0,
    ST_REUSED   = 4'd1,
    ST_STAGING  = 4'd2,
    ST_BAD      = 4'd3,
    ST_OVERLAP  = 4'd4,
    ST_FULL     = 4'd5,
    ST_DROPPED  = 4'd6,
    ST_REMOVED  = 4'd7,
    ST_NOTFOUND = 4'd8,
    ST_BUSY     = 4'd9,
    ST_RESOLVED = 4'd10,
    ST_UNREG    = 4'd11,
    ST_RANGE    = 4'd12,
    ST_RELEASED = 4'd13,
    ST_RELERR   = 4'd14,
    ST_LIMIT    = 4'd15
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DECIDE,
    S_WRITE,
    S_OUT
  } fsm_t;
endpackage

/* rtl/core/rrtt_if.sv */
// valid/ready channel interfaces for items in and results out
interface rrtt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] region_addr;
  logic [63:0] length;
  logic signed [63:0] offset;
  logic [63:0] host_base;
  logic [7:0]  slot;
  modport source (output valid, mode, region_addr, length, offset, host_base, slot,
                  input ready);
  modport sink (input valid, mode, region_addr, length, offset, host_base, slot,
                output ready);
endinterface

interface rrtt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [63:0] host_addr;
  logic [7:0]  entry_index;
  logic        drained;
  modport source (output valid, status, host_addr, entry_index, drained, input ready);
  modport sink (input valid, status, host_addr, entry_index, drained, output ready);
endinterface

/* rtl/core/rrtt_ram.sv */
// generic single-port-write ram with registered read
module rrtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/region_registration_translation_table_unit.sv */
// top level of the region registration translation table
// Usage: items enter on in_ (valid/ready) carrying mode, region_addr, length,
// offset, host_base and slot; one result per item leaves on out_ with status,
// host_addr, entry_index and drained. Configuration (page_shift at index 0,
// staging_mode at index 1) is written on cfg_we/cfg_idx/cfg_data while idle.
// The table lives in one synchronous ram (base, length, host base, client and
// io counts per entry) read one entry per cycle; valid bits sit in flops.
// A scan item (register, deregister, resolve) reads every entry in turn, one
// per cycle through the ram port; release reads only the entry at its slot.
// Writeback goes into the same ram.
// One item is in work at a time; in_ready is high only when the unit is idle.
// The result is held in an output register until out_ready; a stalled
// receiver holds the unit idle-waiting, nothing is dropped.
// Reset clears the valid bits, the state machine and the config registers
// (page_shift 21, staging off); ram contents need no clearing.
module region_registration_translation_table_unit #(
  parameter int ENTRIES  = rrtt_pkg::ENTRIES_DEF,
  parameter int REF_BITS = rrtt_pkg::REF_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rrtt_in_if.sink                        in_ch,
  rrtt_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rrtt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rrtt_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = IW + 1;
  localparam int RW = 64 * 3 + REF_BITS * 2;
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);

  rrtt_pkg::fsm_t state_r, state_nxt;

  // configuration
  logic [5:0] page_shift_r;
  logic       staging_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r <= 6'd21;
      staging_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        rrtt_pkg::CFG_PAGE_SHIFT: page_shift_r <= cfg_data;
        rrtt_pkg::CFG_STAGING:    staging_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0]  mode_r;
  logic [63:0] addr_r, len_r, off_r, hb_r;
  logic [7:0]  slot_r;

  // ram port
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  rrtt_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [63:0]         e_base, e_len, e_hb;
  logic [REF_BITS-1:0] e_cref, e_ioref;
  assign {e_base, e_len, e_hb, e_cref, e_ioref} = ram_rdata;

  logic [ENTRIES-1:0] valid_r;

  // scan bookkeeping
  logic [CW-1:0] rd_cnt_r;     // next address issued
  logic [IW-1:0] chk_idx_r;    // index of data on ram_rdata
  logic          chk_v_r;      // ram_rdata holds a scanned entry
  logic          hit_r, ovl_r;
  logic [IW-1:0] hit_idx_r;
  logic [63:0]   hb_hit_r, base_hit_r, len_hit_r;
  logic [REF_BITS-1:0] cref_hit_r, ioref_hit_r;

  // result register
  logic [3:0]  o_status_r;
  logic [63:0] o_host_r;
  logic [7:0]  o_idx_r;
  logic        o_drain_r;
  logic        o_valid_r;

  // write staging
  logic          wr_en_r;
  logic [IW-1:0] wr_idx_r;
  logic [RW-1:0] wr_data_r;
  logic          wr_setv_r, wr_clrv_r;

  wire accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == rrtt_pkg::S_IDLE) && !o_valid_r;

  assign out_ch.valid       = o_valid_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.host_addr   = o_host_r;
  assign out_ch.entry_index = o_idx_r;
  assign out_ch.drained     = o_drain_r;

  // lowest free slot from valid flops
  logic          free_any;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // per-entry match tests on the entry just read
  logic [63:0] mask;
  logic [63:0] end_a, e_end, inner;
  logic        m_exact, m_ovl, m_base, m_contain;
  always_comb begin
    mask      = (64'd1 << page_shift_r) - 64'd1;
    end_a     = addr_r + len_r;
    e_end     = e_base + e_len;
    inner     = addr_r - e_base;
    m_exact   = (e_base == addr_r) && (e_len == len_r);
    m_ovl     = (e_base < end_a) && (addr_r < e_end);
    m_base    = (e_base == addr_r);
    m_contain = (e_base <= addr_r) && (inner < e_len);
  end

  wire slot_ok = ({1'b0, slot_r} < 9'(ENTRIES));
  wire [IW-1:0] slot_i = slot_r[IW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrtt_pkg::S_IDLE:   if (accept) state_nxt = rrtt_pkg::S_SCAN;
      rrtt_pkg::S_SCAN:   if (rd_cnt_r == LAST || mode_r == rrtt_pkg::MODE_REL)
                            state_nxt = rrtt_pkg::S_WAIT;
      rrtt_pkg::S_WAIT:   state_nxt = rrtt_pkg::S_DECIDE;
      rrtt_pkg::S_DECIDE: state_nxt = rrtt_pkg::S_WRITE;
      rrtt_pkg::S_WRITE:  state_nxt = rrtt_pkg::S_OUT;
      rrtt_pkg::S_OUT:    state_nxt = rrtt_pkg::S_IDLE;
      default:            state_nxt = rrtt_pkg::S_IDLE;
    endcase
  end

  // ram port control
  always_comb begin
    ram_raddr = (mode_r == rrtt_pkg::MODE_REL) ? slot_i : rd_cnt_r[IW-1:0];
    ram_we    = wr_en_r && (state_r == rrtt_pkg::S_WRITE);
    ram_waddr = wr_idx_r;
    ram_wdata = wr_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rrtt_pkg::S_IDLE;
      valid_r   <= '0;
      o_valid_r <= 1'b0;
      chk_v_r   <= 1'b0;
      wr_en_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (o_valid_r && out_ch.ready) o_valid_r <= 1'b0;
      case (state_r)
        rrtt_pkg::S_IDLE: begin
          chk_v_r <= 1'b0;
          wr_en_r <= 1'b0;
          if (accept) begin
            mode_r   <= in_ch.mode;
            addr_r   <= in_ch.region_addr;
            len_r    <= in_ch.length;
            off_r    <= in_ch.offset;
            hb_r     <= in_ch.host_base;
            slot_r   <= in_ch.slot;
            rd_cnt_r <= '0;
            hit_r    <= 1'b0;
            ovl_r    <= 1'b0;
          end
        end
        rrtt_pkg::S_SCAN, rrtt_pkg::S_WAIT: begin
          if (state_r == rrtt_pkg::S_SCAN) begin
            chk_idx_r <= ram_raddr;
            chk_v_r   <= 1'b1;
            if (rd_cnt_r != LAST) rd_cnt_r <= rd_cnt_r + CW'(1);
          end else begin
            chk_v_r <= 1'b0;
          end
          // check the entry read last cycle
          if (chk_v_r && valid_r[chk_idx_r] && !hit_r) begin
            logic found;
            case (mode_r)
              rrtt_pkg::MODE_REG:   found = m_exact;
              rrtt_pkg::MODE_DEREG: found = m_base;
              rrtt_pkg::MODE_RES:   found = m_contain;
              default:              found = 1'b1;
            endcase
            if (found) begin
              hit_r       <= 1'b1;
              hit_idx_r   <= chk_idx_r;
              hb_hit_r    <= e_hb;
              base_hit_r  <= e_base;
              len_hit_r   <= e_len;
              cref_hit_r  <= e_cref;
              ioref_hit_r <= e_ioref;
            end else if (mode_r == rrtt_pkg::MODE_REG && m_ovl) begin
              ovl_r <= 1'b1;
            end
          end
        end
        rrtt_pkg::S_DECIDE: begin
          logic [63:0] in_h, rem;
          in_h = addr_r - base_hit_r;
          rem  = len_hit_r - in_h;
          o_host_r  <= '0;
          o_idx_r   <= '0;
          o_drain_r <= 1'b0;
          wr_en_r   <= 1'b0;
          wr_setv_r <= 1'b0;
          wr_clrv_r <= 1'b0;
          wr_idx_r  <= hit_idx_r;
          wr_data_r <= {base_hit_r, len_hit_r, hb_hit_r, cref_hit_r, ioref_hit_r};
          case (mode_r)
            rrtt_pkg::MODE_REG: begin
              if (addr_r == 64'd0 || len_r == 64'd0 || addr_r > ~len_r)
                o_status_r <= rrtt_pkg::ST_BAD;
              else if (staging_r) begin
                o_status_r <= rrtt_pkg::ST_STAGING;
                o_host_r   <= addr_r;
              end else if ((addr_r & mask) != 64'd0 || (len_r & mask) != 64'd0)
                o_status_r <= rrtt_pkg::ST_BAD;
              else if (hit_r) begin
                o_idx_r <= 8'(hit_idx_r);
                if (cref_hit_r == REF_MAX) o_status_r <= rrtt_pkg::ST_LIMIT;
                else begin
                  o_status_r <= rrtt_pkg::ST_REUSED;
                  o_host_r   <= hb_hit_r;
                  wr_en_r    <= 1'b1;
                  wr_data_r  <= {base_hit_r, len_hit_r, hb_hit_r,
                                 cref_hit_r + REF_BITS'(1), ioref_hit_r};
                end
              end else if (ovl_r) o_status_r <= rrtt_pkg::ST_OVERLAP;
              else if (!free_any) o_status_r <= rrtt_pkg::ST_FULL;
              else begin
                o_status_r <= rrtt_pkg::ST_NEW;
                o_host_r   <= hb_r;
                o_idx_r    <= 8'(free_idx);
                wr_en_r    <= 1'b1;
                wr_setv_r  <= 1'b1;
                wr_idx_r   <= free_idx;
                wr_data_r  <= {addr_r, len_r, hb_r, REF_BITS'(1), REF_BITS'(0)};
              end
            end
            rrtt_pkg::MODE_DEREG: begin
              if (staging_r) o_status_r <= rrtt_pkg::ST_STAGING;
              else if (!hit_r || len_hit_r != len_r) o_status_r <= rrtt_pkg::ST_NOTFOUND;
              else begin
                o_idx_r <= 8'(hit_idx_r);
                if (cref_hit_r > REF_BITS'(1)) begin
                  o_status_r <= rrtt_pkg::ST_DROPPED;
                  wr_en_r    <= 1'b1;
                  wr_data_r  <= {base_hit_r, len_hit_r, hb_hit_r,
                                 cref_hit_r - REF_BITS'(1), ioref_hit_r};
                end else if (ioref_hit_r != '0) o_status_r <= rrtt_pkg::ST_BUSY;
                else begin
                  o_status_r <= rrtt_pkg::ST_REMOVED;
                  wr_clrv_r  <= 1'b1;
                end
              end
            end
            rrtt_pkg::MODE_RES: begin
              if (off_r[63]) o_status_r <= rrtt_pkg::ST_RANGE;
              else if (!hit_r) o_status_r <= rrtt_pkg::ST_UNREG;
              else begin
                o_idx_r <= 8'(hit_idx_r);
                if (off_r > rem || len_r > rem - off_r) o_status_r <= rrtt_pkg::ST_RANGE;
                else if (ioref_hit_r == REF_MAX) o_status_r <= rrtt_pkg::ST_LIMIT;
                else begin
                  o_status_r <= rrtt_pkg::ST_RESOLVED;
                  o_host_r   <= hb_hit_r + in_h + off_r;
                  wr_en_r    <= 1'b1;
                  wr_data_r  <= {base_hit_r, len_hit_r, hb_hit_r, cref_hit_r,
                                 ioref_hit_r + REF_BITS'(1)};
                end
              end
            end
            default: begin
              o_idx_r <= slot_ok ? slot_r : 8'd0;
              if (!slot_ok || !valid_r[slot_i] || ioref_hit_r == '0)
                o_status_r <= rrtt_pkg::ST_RELERR;
              else begin
                o_status_r <= rrtt_pkg::ST_RELEASED;
                o_drain_r  <= (ioref_hit_r == REF_BITS'(1));
                wr_en_r    <= 1'b1;
                wr_idx_r   <= slot_i;
                wr_data_r  <= {base_hit_r, len_hit_r, hb_hit_r, cref_hit_r,
                               ioref_hit_r - REF_BITS'(1)};
              end
            end
          endcase
        end
        rrtt_pkg::S_WRITE: begin
          if (wr_setv_r) valid_r[wr_idx_r] <= 1'b1;
          if (wr_clrv_r) valid_r[wr_idx_r] <= 1'b0;
        end
        rrtt_pkg::S_OUT: o_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // a result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && !out_ch.ready) |=> o_valid_r)
    else $error("result lost under stall");
  // no item accepted while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> !accept)
    else $error("item accepted with result pending");
  // ram written only in the writeback state
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == rrtt_pkg::S_WRITE))
    else $error("ram write outside writeback");
  // a new entry lands only in a free slot
  a_new_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrtt_pkg::S_WRITE && wr_setv_r) |-> !valid_r[wr_idx_r])
    else $error("new entry over a live slot");
endmodule

/* tb/region_registration_translation_table_unit_sb.sv */
// region table predictor and result scoreboard
`timescale 1ns / 1ps
package region_table_sb_pkg;
  import rrtt_pkg::*;

  localparam int NSLOT = 16;
  localparam longint unsigned COUNT_MAX = 64'hFFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] region_addr;
    logic [63:0] length;
    logic [63:0] offset;
    logic [63:0] host_base;
    logic [7:0]  slot;
  } request_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] host_addr;
    logic [7:0]  entry_index;
    logic        drained;
  } answer_t;

  class region_table_sb;
    bit [5:0]  page_shift;
    bit        staging;
    bit        live [NSLOT];
    bit [63:0] base [NSLOT];
    bit [63:0] size [NSLOT];
    bit [63:0] hbase [NSLOT];
    bit [63:0] clients [NSLOT];
    bit [63:0] ios [NSLOT];
    answer_t   pending [$];
    int        mismatches;

    function new();
      page_shift = 21;
      staging = 0;
      mismatches = 0;
      foreach (live[i]) live[i] = 0;
    endfunction

    function void set_reg(bit idx, bit [5:0] val);
      if (idx == CFG_PAGE_SHIFT) page_shift = val;
      else staging = val[0];
    endfunction

    function answer_t mk(status_t st, bit [63:0] h, bit [7:0] i, bit d);
      answer_t r;
      r.status = st; r.host_addr = h; r.entry_index = i; r.drained = d;
      return r;
    endfunction

    function answer_t do_register(request_t q);
      bit [63:0] mask, e;
      bit ovl;
      mask = (64'd1 << page_shift) - 1;
      ovl = 0;
      if (q.region_addr == 0 || q.length == 0 || q.region_addr > ~q.length)
        return mk(ST_BAD, 0, 0, 0);
      if (staging) return mk(ST_STAGING, q.region_addr, 0, 0);
      if ((q.region_addr & mask) != 0 || (q.length & mask) != 0) return mk(ST_BAD, 0, 0, 0);
      e = q.region_addr + q.length;
      for (int i = 0; i < NSLOT; i++) begin
        if (!live[i]) continue;
        if (base[i] == q.region_addr && size[i] == q.length) begin
          if (clients[i] >= COUNT_MAX) return mk(ST_LIMIT, 0, 8'(i), 0);
          clients[i]++;
          return mk(ST_REUSED, hbase[i], 8'(i), 0);
        end
        if (base[i] < e && q.region_addr < base[i] + size[i]) ovl = 1;
      end
      if (ovl) return mk(ST_OVERLAP, 0, 0, 0);
      for (int i = 0; i < NSLOT; i++) begin
        if (!live[i]) begin
          live[i] = 1; base[i] = q.region_addr; size[i] = q.length;
          hbase[i] = q.host_base; clients[i] = 1; ios[i] = 0;
          return mk(ST_NEW, q.host_base, 8'(i), 0);
        end
      end
      return mk(ST_FULL, 0, 0, 0);
    endfunction

    function answer_t do_deregister(request_t q);
      int i;
      if (staging) return mk(ST_STAGING, 0, 0, 0);
      for (i = 0; i < NSLOT; i++)
        if (live[i] && base[i] == q.region_addr) break;
      if (i >= NSLOT || size[i] != q.length) return mk(ST_NOTFOUND, 0, 0, 0);
      if (clients[i] > 1) begin
        clients[i]--;
        return mk(ST_DROPPED, 0, 8'(i), 0);
      end
      if (ios[i] > 0) return mk(ST_BUSY, 0, 8'(i), 0);
      live[i] = 0;
      return mk(ST_REMOVED, 0, 8'(i), 0);
    endfunction

    function answer_t do_resolve(request_t q);
      bit [63:0] inner, len;
      int i;
      if (q.offset[63]) return mk(ST_RANGE, 0, 0, 0);
      for (i = 0; i < NSLOT; i++)
        if (live[i] && base[i] <= q.region_addr && q.region_addr - base[i] < size[i]) break;
      if (i >= NSLOT) return mk(ST_UNREG, 0, 0, 0);
      inner = q.region_addr - base[i];
      len = size[i];
      if (inner > len || q.offset > len - inner || q.length > len - inner - q.offset)
        return mk(ST_RANGE, 0, 8'(i), 0);
      if (ios[i] >= COUNT_MAX) return mk(ST_LIMIT, 0, 8'(i), 0);
      ios[i]++;
      return mk(ST_RESOLVED, hbase[i] + inner + q.offset, 8'(i), 0);
    endfunction

    function answer_t do_release(request_t q);
      if (q.slot >= NSLOT) return mk(ST_RELERR, 0, 0, 0);
      if (!live[q.slot] || ios[q.slot] == 0) return mk(ST_RELERR, 0, q.slot, 0);
      ios[q.slot]--;
      return mk(ST_RELEASED, 0, q.slot, ios[q.slot] == 0);
    endfunction

    // note one accepted item and queue its expected result
    function void note_item(request_t q);
      answer_t r;
      case (mode_t'(q.mode))
        MODE_REG:   r = do_register(q);
        MODE_DEREG: r = do_deregister(q);
        MODE_RES:   r = do_resolve(q);
        default:    r = do_release(q);
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass
endpackage

/* tb/region_registration_translation_table_unit_test.sv */
// top level testbench of the region registration translation table
`timescale 1ns / 1ps
module region_registration_translation_table_unit_test;
  import rrtt_pkg::*;
  import region_table_sb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rrtt_in_if  in_ch ();
  rrtt_out_if out_ch ();

  region_registration_translation_table_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  region_table_sb sb = new();

  // control of receiver behavior
  bit calm = 0;       // no idling in the last part
  int hold_off = 0;   // requested long stall, in cycles
  bit [5:0] cur_shift = 21;
  int res_seen = 0;

  // base of registered regions the generator tracks for well-formed sequences
  bit [63:0] known_base [$];
  bit [63:0] known_len [$];

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    in_ch.valid = 0; in_ch.mode = 0; in_ch.region_addr = 0; in_ch.length = 0;
    in_ch.offset = 0; in_ch.host_base = 0; in_ch.slot = 0;
    out_ch.ready = 0;
  end

  // monitor: record accepted items and check results at the rising edge
  always @(posedge clk) begin
    request_t q;
    answer_t a;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      q.mode = in_ch.mode; q.region_addr = in_ch.region_addr; q.length = in_ch.length;
      q.offset = in_ch.offset; q.host_base = in_ch.host_base; q.slot = in_ch.slot;
      sb.note_item(q);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a.status = out_ch.status; a.host_addr = out_ch.host_addr;
      a.entry_index = out_ch.entry_index; a.drained = out_ch.drained;
      sb.check_result(a);
      res_seen++;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ch.ready <= 0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        n = $urandom_range(1, 19);
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready <= 1;
        n = $urandom_range(1, 30);
        repeat (n) begin
          @(negedge clk);
          if (hold_off != 0) break;
        end
      end
    end
  end

  // send one item; inputs change at the falling edge
  task automatic send(bit [1:0] m, bit [63:0] a, bit [63:0] l, bit [63:0] o,
                      bit [63:0] h, bit [7:0] s);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 19);
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1; in_ch.mode <= m; in_ch.region_addr <= a; in_ch.length <= l;
    in_ch.offset <= o; in_ch.host_base <= h; in_ch.slot <= s;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid <= 0;
    // the unit is busy after an accept until its result has been taken
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(bit idx, bit [5:0] v);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    if (idx == CFG_PAGE_SHIFT) cur_shift = v;
  endtask

  function automatic bit [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  // one random item, mostly aimed at the table contents
  task automatic random_item();
    bit [63:0] b, l, unit, off;
    int k, pick;
    unit = 64'd1 << cur_shift;
    pick = $urandom_range(0, 99);
    k = known_base.size() ? $urandom_range(0, known_base.size() - 1) : 0;
    if (pick < 30 || known_base.size() == 0) begin
      // aligned register, small sizes, sometimes an exact duplicate
      if (known_base.size() && $urandom_range(0, 3) == 0) begin
        b = known_base[k]; l = known_len[k];
      end else begin
        b = unit * $urandom_range(1, 60);
        l = unit * $urandom_range(1, 4);
        if (known_base.size() < 40) begin
          known_base.push_back(b); known_len.push_back(l);
        end
      end
      send(MODE_REG, b, l, 0, r64(), 0);
    end else if (pick < 50) begin
      off = $urandom_range(0, 3) ? 64'($urandom_range(0, 4096)) : r64();
      b = known_base[k] + ($urandom_range(0, 1) ? 0 : 64'($urandom_range(0, 8192)));
      send(MODE_RES, b, 64'($urandom_range(0, 2) ? $urandom_range(0, 4096) : $urandom),
           off, r64(), 8'($urandom));
    end else if (pick < 70) begin
      send(MODE_REL, r64(), r64(), r64(), r64(), 8'($urandom_range(0, 19)));
    end else if (pick < 85) begin
      send(MODE_DEREG, known_base[k],
           $urandom_range(0, 7) ? known_len[k] : known_len[k] + unit, r64(), r64(), 0);
    end else begin
      send(2'($urandom_range(0, 3)), r64(), r64(), r64(), r64(), 8'($urandom));
    end
  endtask

  initial begin
    bit [63:0] big;
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes and each special case at reset settings
    big = 64'd1 << 21;
    send(MODE_REG, 0, big, 0, 0, 0);                          // zero base
    send(MODE_REG, big, 0, 0, 0, 0);                          // zero length
    send(MODE_REG, 64'hFFFF_FFFF_FFE0_0000, big * 2, 0, 0, 0); // wraps
    send(MODE_REG, big + 1, big, 0, 0, 0);                    // misaligned
    send(MODE_REG, big, big * 4, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0); // new
    send(MODE_REG, big, big * 4, 0, 0, 0);                    // reuse
    send(MODE_REG, big * 2, big, 0, 0, 0);                    // overlap
    send(MODE_RES, big + 16, 8, 64'sd16, 0, 0);               // resolved, wraps
    send(MODE_RES, big, 8, -64'sd1, 0, 0);                    // negative offset
    send(MODE_RES, 64'd5, 8, 0, 0, 0);                        // unregistered
    send(MODE_RES, big, big * 4 + 1, 0, 0, 0);                // past end
    send(MODE_DEREG, big, big, 0, 0, 0);                      // wrong length
    send(MODE_DEREG, big, big * 4, 0, 0, 0);                  // ref dropped
    send(MODE_DEREG, big, big * 4, 0, 0, 0);                  // busy
    send(MODE_REL, 0, 0, 0, 0, 8'd0);                         // released, drained
    send(MODE_REL, 0, 0, 0, 0, 8'd0);                         // zero io refs
    send(MODE_REL, 0, 0, 0, 0, 8'd255);                       // beyond table
    send(MODE_REL, 0, 0, 0, 0, 8'd7);                         // invalid slot
    send(MODE_DEREG, big, big * 4, 0, 0, 0);                  // removed
    for (int i = 1; i <= 17; i++)                             // fill, then full
      send(MODE_REG, big * 8 * i, big, 0, 64'(i), 0);
    drain();

    // staging mode, then page shift extremes
    write_reg(CFG_STAGING, 1);
    send(MODE_REG, 64'h123, 64'h5, 0, 0, 0);
    send(MODE_REG, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0);
    send(MODE_DEREG, 64'h8, 64'h8, 0, 0, 0);
    drain();
    write_reg(CFG_STAGING, 0);
    for (int i = 1; i <= 17; i++)                             // empty the table
      send(MODE_DEREG, big * 8 * i, big, 0, 0, 0);
    drain();

    // random phases over several settings; table is reset by deregistering
    foreach (known_base[i]) ;
    for (int ph = 0; ph < 5; ph++) begin
      bit [5:0] sh;
      sh = (ph == 0) ? 6'd0 : (ph == 1) ? 6'd40 : (ph == 4) ? 6'd12 : 6'($urandom_range(1, 39));
      // clear table of leftovers before changing alignment
      for (int i = 0; i < 16; i++) if (sb.live[i]) begin
        while (sb.ios[i] > 0) begin
          send(MODE_REL, 0, 0, 0, 0, 8'(i));
          drain();
        end
        while (sb.live[i]) begin
          send(MODE_DEREG, sb.base[i], sb.size[i], 0, 0, 0);
          drain();
        end
      end
      write_reg(CFG_PAGE_SHIFT, sh);
      known_base.delete(); known_len.delete();
      if (ph == 2) begin
        hold_off = 200;           // long receiver hold-off while items keep coming
      end
      if (ph == 4) calm = 1;
      repeat (150) random_item();
      drain();                    // sender pause until everything has come back
    end
    write_reg(CFG_STAGING, 1);
    repeat (10) random_item();
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("region_registration_translation_table_unit_test: done, clean");
    else
      $display("region_registration_translation_table_unit_test: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("region_registration_translation_table_unit_test: done, errors");
    $finish;
  end
endmodule

/* files.f */
rtl/core/rrtt_pkg.sv
rtl/core/rrtt_if.sv
rtl/core/rrtt_ram.sv
rtl/core/region_registration_translation_table_unit.sv
tb/region_registration_translation_table_unit_sb.sv
tb/region_registration_translation_table_unit_test.sv
